@@ hw/rtl/hdlc_dfr_pkg.sv @@
package hdlc_dfr_pkg;

  localparam int CountWidth = 16;
  localparam int CmpWidth = (CountWidth > 16) ? CountWidth : 16;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte = 8'h7D;
  localparam logic [7:0] EscMask = 8'h20;
  localparam logic [15:0] FcsPoly = 16'h8408;
  localparam logic [15:0] FcsInit = 16'hFFFF;
  localparam logic [15:0] FcsGood = 16'hF0B8;
  localparam logic [CountWidth-1:0] FcsBytes = CountWidth'(2);
  localparam logic [15:0] BufSizeReset = 16'd4096;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_GOOD    = 3'd1,
    ST_FCS_ERR = 3'd2,
    ST_DISCARD = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_FLAG,
    KIND_ESC,
    KIND_DATA
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       esc_ok;
    logic [7:0] rx_byte;
  } cmd_t;

  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] v;
    v = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ FcsPoly;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/hdlc_dfr_in_if.sv @@
interface hdlc_dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/hdlc_dfr_out_if.sv @@
interface hdlc_dfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [15:0] data_index;
  logic [15:0] frame_length;

  modport source (
    output valid, output status, output data_valid, output data_byte,
    output data_index, output frame_length, input ready
  );
  modport sink (
    input valid, input status, input data_valid, input data_byte,
    input data_index, input frame_length, output ready
  );
endinterface

@@ hw/rtl/hdlc_dfr_front.sv @@
module hdlc_dfr_front (
  input  logic [7:0]         rx_byte,
  output hdlc_dfr_pkg::cmd_t cmd
);

  always_comb begin
    cmd.rx_byte = rx_byte;
    cmd.esc_ok = (rx_byte == (hdlc_dfr_pkg::FlagByte ^ hdlc_dfr_pkg::EscMask)) ||
                 (rx_byte == (hdlc_dfr_pkg::EscByte ^ hdlc_dfr_pkg::EscMask));
    if (rx_byte == hdlc_dfr_pkg::FlagByte) begin
      cmd.kind = hdlc_dfr_pkg::KIND_FLAG;
    end else if (rx_byte == hdlc_dfr_pkg::EscByte) begin
      cmd.kind = hdlc_dfr_pkg::KIND_ESC;
    end else begin
      cmd.kind = hdlc_dfr_pkg::KIND_DATA;
    end
  end

endmodule

@@ hw/rtl/hdlc_dfr_fifo.sv @@
module hdlc_dfr_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hdlc_dfr_pkg::cmd_t push_cmd,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output hdlc_dfr_pkg::cmd_t head,
  output logic [1:0]         level
);

  hdlc_dfr_pkg::cmd_t mem [2];
  logic wr_ptr;
  logic rd_ptr;

  assign not_full = (level != 2'd2);
  assign not_empty = (level != 2'd0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && not_full) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push && not_full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      level <= level + 2'(push && not_full) - 2'(pop && not_empty);
    end
  end

endmodule

@@ hw/rtl/hdlc_dfr_back.sv @@
module hdlc_dfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  logic                 cmd_valid,
  input  hdlc_dfr_pkg::cmd_t   cmd,
  output logic                 cmd_pop,
  hdlc_dfr_out_if.source       result
);

  localparam int Cw = hdlc_dfr_pkg::CountWidth;
  localparam int Mw = hdlc_dfr_pkg::CmpWidth;

  logic          hunting, hunting_next;
  logic          esc_pend, esc_pend_next;
  logic [Cw-1:0] byte_count, byte_count_next;
  logic [15:0]   fcs, fcs_next;
  logic [15:0]   buffer_size;

  hdlc_dfr_pkg::status_t st;
  logic        dv;
  logic [7:0]  db;
  logic [15:0] flen;
  logic [7:0]  b;
  logic        full;
  logic        take;

  assign take = cmd_valid && (!result.valid || result.ready);
  assign cmd_pop = take;
  assign full = (Mw'(byte_count) >= Mw'(buffer_size)) || (byte_count == {Cw{1'b1}});

  always_comb begin
    hunting_next = hunting;
    esc_pend_next = esc_pend;
    byte_count_next = byte_count;
    fcs_next = fcs;
    st = hdlc_dfr_pkg::ST_NONE;
    dv = 1'b0;
    db = 8'h00;
    flen = 16'h0000;
    b = cmd.rx_byte;
    if (hunting && cmd.kind != hdlc_dfr_pkg::KIND_FLAG) begin
      esc_pend_next = 1'b0;
      byte_count_next = '0;
      fcs_next = hdlc_dfr_pkg::FcsInit;
    end else begin
      case (cmd.kind)
        hdlc_dfr_pkg::KIND_FLAG: begin
          hunting_next = 1'b0;
          if (byte_count > hdlc_dfr_pkg::FcsBytes) begin
            if (fcs == hdlc_dfr_pkg::FcsGood) begin
              st = hdlc_dfr_pkg::ST_GOOD;
              flen = 16'(byte_count - hdlc_dfr_pkg::FcsBytes);
            end else begin
              st = hdlc_dfr_pkg::ST_FCS_ERR;
            end
          end
          esc_pend_next = 1'b0;
          byte_count_next = '0;
          fcs_next = hdlc_dfr_pkg::FcsInit;
        end
        hdlc_dfr_pkg::KIND_ESC: begin
          if (!esc_pend) begin
            esc_pend_next = 1'b1;
          end else begin
            st = hdlc_dfr_pkg::ST_DISCARD;
            hunting_next = 1'b1;
            esc_pend_next = 1'b0;
            byte_count_next = '0;
            fcs_next = hdlc_dfr_pkg::FcsInit;
          end
        end
        default: begin
          if (full) begin
            st = hdlc_dfr_pkg::ST_FULL;
            hunting_next = 1'b1;
            esc_pend_next = 1'b0;
            byte_count_next = '0;
            fcs_next = hdlc_dfr_pkg::FcsInit;
          end else if (esc_pend && !cmd.esc_ok) begin
            st = hdlc_dfr_pkg::ST_DISCARD;
            hunting_next = 1'b1;
            esc_pend_next = 1'b0;
            byte_count_next = '0;
            fcs_next = hdlc_dfr_pkg::FcsInit;
          end else begin
            if (esc_pend) begin
              b = cmd.rx_byte ^ hdlc_dfr_pkg::EscMask;
            end
            esc_pend_next = 1'b0;
            dv = 1'b1;
            db = b;
            fcs_next = hdlc_dfr_pkg::fcs_update(fcs, b);
            byte_count_next = byte_count + Cw'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting <= 1'b1;
      esc_pend <= 1'b0;
      byte_count <= '0;
      fcs <= hdlc_dfr_pkg::FcsInit;
      buffer_size <= hdlc_dfr_pkg::BufSizeReset;
      result.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_size <= cfg_data;
      end
      if (take) begin
        hunting <= hunting_next;
        esc_pend <= esc_pend_next;
        byte_count <= byte_count_next;
        fcs <= fcs_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (take) begin
      result.status <= st;
      result.data_valid <= dv;
      result.data_byte <= db;
      result.data_index <= dv ? 16'(byte_count) : 16'h0000;
      result.frame_length <= flen;
    end
  end

endmodule

@@ hw/rtl/hdlc_async_deframer_unit.sv @@
// each byte passes through the request queue, then its result is registered in the output register
// throughput: one byte per cycle while results are taken, set by the back end's state update
// a two-entry request queue lets input and output stall independently
// reset (rst, synchronous): hunting for a flag, escape cleared, count 0, fcs 0xffff,
// buffer_size 4096, queue and output register empty
module hdlc_async_deframer_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  hdlc_dfr_in_if.sink   rx,
  hdlc_dfr_out_if.source result
);

  hdlc_dfr_pkg::cmd_t in_cmd;
  hdlc_dfr_pkg::cmd_t head;
  logic       not_full;
  logic       not_empty;
  logic       pop;
  logic [1:0] level;

  assign rx.ready = not_full;

  hdlc_dfr_front u_front (
    .rx_byte (rx.rx_byte),
    .cmd     (in_cmd)
  );

  hdlc_dfr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rx.valid),
    .push_cmd  (in_cmd),
    .not_full  (not_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .level     (level)
  );

  hdlc_dfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (not_empty),
    .cmd       (head),
    .cmd_pop   (pop),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_data_no_status: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data_valid) |->
      (result.status == hdlc_dfr_pkg::ST_NONE && result.frame_length == 16'h0000))
    else $error("stored byte reported with frame status");

  a_len_only_good: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != hdlc_dfr_pkg::ST_GOOD) |->
      (result.frame_length == 16'h0000))
    else $error("frame length without good frame");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (level != 2'd3) && !((level == 2'd0) && pop))
    else $error("queue level out of range or pop from empty queue");
`endif

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hdlc_dfr_pkg::*;

  typedef struct packed {
    status_t     status;
    logic        dv;
    logic [7:0]  db;
    logic [15:0] idx;
    logic [15:0] flen;
  } deframe_res_t;

  typedef struct packed {
    logic [7:0]   raw;
    logic         typed;
    deframe_res_t want;
  } dir_row_t;

  localparam deframe_res_t Quiet = '{ST_NONE, 1'b0, 8'h00, 16'd0, 16'd0};
  localparam deframe_res_t Discard = '{ST_DISCARD, 1'b0, 8'h00, 16'd0, 16'd0};
  localparam int StallLimit = 5000;
  localparam int SegItems = 190;
  localparam int HoldAfter = 700;
  localparam int HoldCycles = 400;
  localparam int MaxReports = 200;
  localparam logic [15:0] SegCap [8] = '{16'd3, 16'd0, 16'd1, 16'd24,
                                         16'd65535, 16'd2, 16'd8, 16'd40};

  // "123456789" carries the well-known check fcs 0x906e, sent low byte first
  localparam dir_row_t DirectedRows [26] = '{
    '{8'hFF, 1'b1, Quiet},
    '{8'h7E, 1'b1, Quiet},
    '{8'h7E, 1'b1, Quiet},
    '{8'h31, 1'b0, Quiet},
    '{8'h32, 1'b0, Quiet},
    '{8'h33, 1'b0, Quiet},
    '{8'h34, 1'b0, Quiet},
    '{8'h35, 1'b0, Quiet},
    '{8'h36, 1'b0, Quiet},
    '{8'h37, 1'b0, Quiet},
    '{8'h38, 1'b0, Quiet},
    '{8'h39, 1'b0, Quiet},
    '{8'h6E, 1'b0, Quiet},
    '{8'h90, 1'b0, Quiet},
    '{8'h7E, 1'b1, '{ST_GOOD, 1'b0, 8'h00, 16'd0, 16'd9}},
    '{8'h7D, 1'b0, Quiet},
    '{8'h5D, 1'b1, '{ST_NONE, 1'b1, 8'h7D, 16'd0, 16'd0}},
    '{8'h7D, 1'b0, Quiet},
    '{8'h5E, 1'b1, '{ST_NONE, 1'b1, 8'h7E, 16'd1, 16'd0}},
    '{8'h00, 1'b0, Quiet},
    '{8'h7E, 1'b0, Quiet},
    '{8'h7D, 1'b0, Quiet},
    '{8'h7D, 1'b1, Discard},
    '{8'h7E, 1'b1, Quiet},
    '{8'h7D, 1'b0, Quiet},
    '{8'h00, 1'b1, Discard}
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;

  hdlc_dfr_in_if  rx_ch ();
  hdlc_dfr_out_if res_ch ();

  hdlc_async_deframer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rx       (rx_ch),
    .result   (res_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // deframer state as the block should hold it
  logic                  in_hunt;
  logic                  esc_seen;
  logic [CountWidth-1:0] stored_count;
  logic [15:0]           fcs_acc;
  logic [15:0]           buf_cap;

  deframe_res_t pending_results [$];
  int fault_count = 0;
  int bytes_sent = 0;
  int snd_idle_pct = 19;
  int rcv_idle_pct = 58;

  function automatic logic [15:0] fcs_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) begin
        c = c ^ FcsPoly;
      end
    end
    return c;
  endfunction

  function automatic void frame_restart();
    stored_count = '0;
    fcs_acc = FcsInit;
    esc_seen = 1'b0;
  endfunction

  function automatic deframe_res_t deframe_predict(input logic [7:0] raw);
    deframe_res_t r;
    r = Quiet;
    if (in_hunt && raw != FlagByte) begin
      frame_restart();
    end else if (raw == FlagByte) begin
      in_hunt = 1'b0;
      if (stored_count > FcsBytes) begin
        if (fcs_acc == FcsGood) begin
          r.status = ST_GOOD;
          r.flen = 16'(stored_count - FcsBytes);
        end else begin
          r.status = ST_FCS_ERR;
        end
      end
      frame_restart();
    end else if (raw == EscByte) begin
      if (!esc_seen) begin
        esc_seen = 1'b1;
      end else begin
        r.status = ST_DISCARD;
        in_hunt = 1'b1;
        frame_restart();
      end
    end else if (stored_count >= buf_cap || stored_count == {CountWidth{1'b1}}) begin
      r.status = ST_FULL;
      in_hunt = 1'b1;
      frame_restart();
    end else if (esc_seen && raw != (FlagByte ^ EscMask) && raw != (EscByte ^ EscMask)) begin
      r.status = ST_DISCARD;
      in_hunt = 1'b1;
      frame_restart();
    end else begin
      r.dv = 1'b1;
      r.db = esc_seen ? (raw ^ EscMask) : raw;
      r.idx = 16'(stored_count);
      esc_seen = 1'b0;
      fcs_acc = fcs_fold(fcs_acc, r.db);
      stored_count = stored_count + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return FlagByte;
      1: return EscByte;
      2: return $urandom_range(1) ? 8'h5E : 8'h5D;
      3: return $urandom_range(1) ? 8'h00 : 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    pending_results.push_back(deframe_predict(b));
    bytes_sent++;
  endtask

  task automatic send_frame();
    logic [7:0]  body [$];
    logic [7:0]  wire_bytes [$];
    logic [15:0] c;
    logic [7:0]  v;
    int          n;
    int          kind;
    int          pos;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      // line noise
      n = $urandom_range(1, 8);
      repeat (n) push_byte(pick_byte());
      return;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (n) body.push_back(pick_byte());
    c = FcsInit;
    foreach (body[i]) c = fcs_fold(c, body[i]);
    c = ~c;
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    wire_bytes.push_back(FlagByte);
    foreach (body[i]) begin
      if (body[i] == FlagByte || body[i] == EscByte) begin
        wire_bytes.push_back(EscByte);
        wire_bytes.push_back(body[i] ^ EscMask);
      end else begin
        wire_bytes.push_back(body[i]);
      end
    end
    if (kind >= 75) begin
      // double escape, escape before flag, or bad escaped byte
      pos = $urandom_range(1, wire_bytes.size() - 1);
      case ($urandom_range(2))
        0: v = EscByte;
        1: v = FlagByte;
        default: v = 8'($urandom_range(255));
      endcase
      wire_bytes.insert(pos, v);
      wire_bytes.insert(pos, EscByte);
    end else if (kind >= 65) begin
      pos = $urandom_range(1, wire_bytes.size() - 1);
      wire_bytes[pos] = wire_bytes[pos] ^ 8'(1 << $urandom_range(7));
    end
    wire_bytes.push_back(FlagByte);
    foreach (wire_bytes[i]) push_byte(wire_bytes[i]);
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    buf_cap = v;
  endtask

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    deframe_res_t seen;
    deframe_res_t want;
    int           hold_left;
    int           got;
    bit           held_once;
    hold_left = 0;
    got = 0;
    held_once = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        seen.status = status_t'(res_ch.status);
        seen.dv = res_ch.data_valid;
        seen.db = res_ch.data_byte;
        seen.idx = res_ch.data_index;
        seen.flen = res_ch.frame_length;
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= MaxReports) begin
            $display("%0t: unexpected result status %0d valid %0d byte %02h index %0d length %0d",
                     $time, seen.status, seen.dv, seen.db, seen.idx, seen.flen);
          end
        end else begin
          want = pending_results.pop_front();
          if (seen !== want) begin
            fault_count++;
            if (fault_count <= MaxReports) begin
              $display("%0t: mismatch expected %0d/%0d/%02h/%0d/%0d actual %0d/%0d/%02h/%0d/%0d",
                       $time, want.status, want.dv, want.db, want.idx, want.flen,
                       seen.status, seen.dv, seen.db, seen.idx, seen.flen);
            end
          end
        end
        got++;
        if (!held_once && got == HoldAfter) begin
          held_once = 1'b1;
          hold_left = HoldCycles;
        end
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    in_hunt = 1'b1;
    buf_cap = BufSizeReset;
    frame_restart();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DirectedRows[i]) begin
      push_byte(DirectedRows[i].raw);
      if (DirectedRows[i].typed) begin
        pending_results[pending_results.size() - 1] = DirectedRows[i].want;
      end
    end

    for (int seg = 0; seg < 8; seg++) begin
      wait_drained();
      write_buffer_size((seg == 7) ? 16'($urandom_range(4, 64)) : SegCap[seg]);
      mode = seg * 3 / 8;
      snd_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 58 : 0;
      rcv_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 19 : 0;
      bytes_sent = 0;
      while (bytes_sent < SegItems) send_frame();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
